[src/ibt_pkg.sv]
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants of the IoU box tracker.
// ----------------------------------------------------------------------------
package ibt_pkg;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_RECT  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;

	localparam logic [2:0] REG_IOU    = 3'd0;
	localparam logic [2:0] REG_GAIN   = 3'd1;
	localparam logic [2:0] REG_AGE    = 3'd2;
	localparam logic [2:0] REG_MISS   = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_APPEND,
		ST_COMPACT,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic start;
		logic scan_clear;
		logic scan_step;
		logic update;
		logic pend_store;
		logic append_step;
		logic append_done;
		logic compact_step;
		logic emit_step;
		logic emit_empty;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic match;
		logic append_done;
		logic compact_done;
		logic emit_done;
		logic emit_hit;
		logic emit_last;
	} sts_t;

endpackage

[src/ibt_ctrl.sv]
// ----------------------------------------------------------------------------
// ibt_ctrl
// Sequencer of the tracker: steps the datapath through one request.
// ----------------------------------------------------------------------------
module ibt_ctrl import ibt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic       out_free,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_START: state_d = ST_START;
						ACT_RECT:  state_d = ST_SCAN;
						ACT_END:   state_d = ST_APPEND;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_START:   state_d = ST_IDLE;
			ST_SCAN:    if (sts.scan_done) state_d = ST_DECIDE;
			ST_DECIDE:  state_d = ST_UPDATE;
			ST_UPDATE:  state_d = ST_IDLE;
			ST_APPEND:  if (sts.append_done) state_d = ST_COMPACT;
			ST_COMPACT: if (sts.compact_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.emit_done) begin
					state_d = ST_EMPTY;
				end else if (out_free && sts.emit_hit && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY:   if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.scan_clear = 1'b1;
			end
			ST_START:   cmd.start = 1'b1;
			ST_SCAN:    cmd.scan_step = 1'b1;
			ST_UPDATE: begin
				cmd.update = sts.match;
				cmd.pend_store = !sts.match;
			end
			ST_APPEND: begin
				cmd.append_step = !sts.append_done;
				cmd.append_done = sts.append_done;
			end
			ST_COMPACT: cmd.compact_step = 1'b1;
			ST_EMIT:    cmd.emit_step = out_free || !sts.emit_hit;
			ST_EMPTY:   cmd.emit_empty = out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

[src/ibt_datapath.sv]
// ----------------------------------------------------------------------------
// ibt_datapath
// Track table, IoU scan with shared multipliers, EMA update, compaction and
// output formatting.
// ----------------------------------------------------------------------------
module ibt_datapath import ibt_pkg::*; #(
	parameter int MAX_TRACKS  = 16,
	parameter int MAX_PENDING = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        in_take,
	input  logic [12:0] rect_x,
	input  logic [12:0] rect_y,
	input  logic [13:0] rect_w,
	input  logic [13:0] rect_h,
	input  logic [8:0]  iou_limit,
	input  logic [8:0]  smoothing_gain,
	input  logic [4:0]  min_age,
	input  logic [4:0]  miss_limit,
	input  logic [13:0] frame_width,
	input  logic [13:0] frame_height,
	output logic        o_load,
	output logic [13:0] o_x,
	output logic [13:0] o_y,
	output logic [13:0] o_w,
	output logic [13:0] o_h,
	output logic        o_present,
	output logic        o_last,
	output logic        o_overflow
);

	localparam int TI = $clog2(MAX_TRACKS);
	localparam int PI = $clog2(MAX_PENDING);
	localparam int CI = (TI > PI) ? TI : PI;
	localparam int SW = 14 + FRAC_BITS;

	logic [TI:0]   cnt_q;
	logic [12:0]   tx_q [MAX_TRACKS];
	logic [12:0]   ty_q [MAX_TRACKS];
	logic [13:0]   tw_q [MAX_TRACKS];
	logic [13:0]   th_q [MAX_TRACKS];
	logic [SW-1:0] s_q  [MAX_TRACKS][4];
	logic [7:0]    age_q [MAX_TRACKS];
	logic [4:0]    miss_q [MAX_TRACKS];
	logic [53:0]   pb_q [MAX_PENDING];
	logic [PI:0]   pcnt_q;
	logic          lost_q;

	logic [12:0] rx_q, ry_q;
	logic [13:0] rw_q, rh_q;
	logic [27:0] ar_q;

	// scan pipeline: stage 1 geometry, stage 2 products, stage 3 compare
	logic [TI:0]  idx_q;
	logic         v_s1, v_s2;
	logic [TI-1:0] j_s1, j_s2;
	logic [13:0]  iw_s1, ih_s1;
	logic [27:0]  ta_s1;
	logic [27:0]  in_s2;
	logic [28:0]  un_s2;
	logic [27:0]  bi_q;
	logic [28:0]  bu_q;
	logic [TI-1:0] bj_q;
	logic         bf_q;
	logic         match_q;

	// compaction and emit
	logic [CI:0] rd_q;
	logic [TI:0] wr_q;
	logic [CI:0] cnt_w;
	logic        lost_cur;

	assign cnt_w = (CI+1)'(cnt_q);

	logic [TI-1:0] js;
	logic [14:0] x2r, x2t, y2r, y2t, x1, y1, x2, y2;
	assign js = idx_q[TI-1:0];
	assign x1  = (rx_q > tx_q[js]) ? {2'b0, rx_q} : {2'b0, tx_q[js]};
	assign y1  = (ry_q > ty_q[js]) ? {2'b0, ry_q} : {2'b0, ty_q[js]};
	assign x2r = {2'b0, rx_q} + {1'b0, rw_q};
	assign x2t = {2'b0, tx_q[js]} + {1'b0, tw_q[js]};
	assign y2r = {2'b0, ry_q} + {1'b0, rh_q};
	assign y2t = {2'b0, ty_q[js]} + {1'b0, th_q[js]};
	assign x2  = (x2r < x2t) ? x2r : x2t;
	assign y2  = (y2r < y2t) ? y2r : y2t;

	logic [56:0] lhs, rhs;
	assign lhs = {29'd0, in_s2} * {28'd0, bu_q};
	assign rhs = {29'd0, bi_q} * {28'd0, un_s2};

	logic [8:0] lim, g;
	assign lim = (iou_limit > 9'd256) ? 9'd256 : iou_limit;
	assign g   = (smoothing_gain > 9'd256) ? 9'd256 : smoothing_gain;

	logic [37:0] thr_l, thr_r;
	assign thr_l = {2'b0, bi_q, 8'd0};
	assign thr_r = {29'd0, lim} * {9'd0, bu_q};

	logic [13:0] rv [4];
	assign rv[0] = {1'b0, rx_q};
	assign rv[1] = {1'b0, ry_q};
	assign rv[2] = rw_q;
	assign rv[3] = rh_q;

	logic [SW+8:0] ema [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ema[k] = (((SW+9)'(g) * (SW+9)'(rv[k])) << FRAC_BITS)
				+ (SW+9)'(9'd256 - g) * (SW+9)'(s_q[bj_q][k]) + (SW+9)'(128);
		end
	end

	logic [TI-1:0] rs, ws;
	assign rs = rd_q[TI-1:0];
	assign ws = wr_q[TI-1:0];
	logic keep;
	assign keep = (rd_q < cnt_w) && (miss_q[rs] <= miss_limit);

	logic [13:0] fw, fh;
	assign fw = (frame_width == 14'd0) ? 14'd1 :
		(frame_width > 14'd8192) ? 14'd8192 : frame_width;
	assign fh = (frame_height == 14'd0) ? 14'd1 :
		(frame_height > 14'd8192) ? 14'd8192 : frame_height;
	logic [4:0] need;
	assign need = (min_age == 5'd0) ? 5'd1 : min_age;

	function automatic logic [13:0] oc(input logic [SW-1:0] s, input logic [13:0] b);
		logic [SW:0] r;
		r = ({1'b0, s} + (SW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		oc = (r > {{(SW-13){1'b0}}, b}) ? b : r[13:0];
	endfunction

	logic hit, more;
	assign hit  = (rd_q < cnt_w) && (age_q[rs] >= {3'd0, need}) && (miss_q[rs] == 5'd0);
	logic [CI:0] nxt;
	always_comb begin
		more = 1'b0;
		for (int j = 0; j < MAX_TRACKS; j++) begin
			if ((CI+1)'(j) > rd_q && (TI+1)'(j) < cnt_q && age_q[j] >= {3'd0, need}
				&& miss_q[j] == 5'd0) more = 1'b1;
		end
		nxt = rd_q + 1'b1;
	end

	assign sts.scan_done    = !v_s1 && !v_s2 && (idx_q >= cnt_q);
	assign sts.match        = match_q;
	assign sts.append_done  = (rd_q >= (CI+1)'(pcnt_q)) || (rd_q >= (CI+1)'(MAX_PENDING));
	assign sts.compact_done = (rd_q >= (CI+1)'(MAX_TRACKS));
	assign sts.emit_done    = (rd_q >= cnt_w);
	assign sts.emit_hit     = hit;
	assign sts.emit_last    = !more;
	assign lost_cur = lost_q;
	assign o_load   = (cmd.emit_step && hit) || cmd.emit_empty;

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_q <= rect_x; ry_q <= rect_y; rw_q <= rect_w; rh_q <= rect_h;
		end
		ar_q <= {14'd0, rw_q} * {14'd0, rh_q};
		j_s1 <= js;
		iw_s1 <= (x2 > x1) ? 14'(x2 - x1) : 14'd0;
		ih_s1 <= (y2 > y1) ? 14'(y2 - y1) : 14'd0;
		ta_s1 <= {14'd0, tw_q[js]} * {14'd0, th_q[js]};
		j_s2 <= j_s1;
		in_s2 <= {14'd0, iw_s1} * {14'd0, ih_s1};
		un_s2 <= {1'b0, ar_q} + {1'b0, ta_s1} - {15'd0, iw_s1} * {15'd0, ih_s1};
		if (o_load) begin
			o_x <= hit ? oc(s_q[rs][0], fw) : 14'd0;
			o_y <= hit ? oc(s_q[rs][1], fh) : 14'd0;
			o_w <= hit ? oc(s_q[rs][2], fw) : 14'd0;
			o_h <= hit ? oc(s_q[rs][3], fh) : 14'd0;
			o_present <= !cmd.emit_empty;
			o_last <= cmd.emit_empty || !more;
			o_overflow <= lost_cur;
		end
		if (cmd.pend_store && pcnt_q < (PI+1)'(MAX_PENDING))
			pb_q[pcnt_q[PI-1:0]] <= {rx_q, ry_q, rw_q, rh_q};
		if (cmd.update) begin
			tx_q[bj_q] <= rx_q; ty_q[bj_q] <= ry_q;
			tw_q[bj_q] <= rw_q; th_q[bj_q] <= rh_q;
			for (int k = 0; k < 4; k++) s_q[bj_q][k] <= SW'(ema[k] >> 8);
			if (age_q[bj_q] != 8'd255) age_q[bj_q] <= age_q[bj_q] + 8'd1;
			miss_q[bj_q] <= 5'd0;
		end
		if (cmd.start) begin
			for (int j = 0; j < MAX_TRACKS; j++)
				if (miss_q[j] != 5'd31) miss_q[j] <= miss_q[j] + 5'd1;
		end
		if (cmd.append_step && cnt_q < (TI+1)'(MAX_TRACKS)) begin
			tx_q[cnt_q[TI-1:0]] <= pb_q[rd_q[PI-1:0]][53:41];
			ty_q[cnt_q[TI-1:0]] <= pb_q[rd_q[PI-1:0]][40:28];
			tw_q[cnt_q[TI-1:0]] <= pb_q[rd_q[PI-1:0]][27:14];
			th_q[cnt_q[TI-1:0]] <= pb_q[rd_q[PI-1:0]][13:0];
			s_q[cnt_q[TI-1:0]][0] <= SW'({pb_q[rd_q[PI-1:0]][53:41], FRAC_BITS'(0)});
			s_q[cnt_q[TI-1:0]][1] <= SW'({pb_q[rd_q[PI-1:0]][40:28], FRAC_BITS'(0)});
			s_q[cnt_q[TI-1:0]][2] <= SW'({pb_q[rd_q[PI-1:0]][27:14], FRAC_BITS'(0)});
			s_q[cnt_q[TI-1:0]][3] <= SW'({pb_q[rd_q[PI-1:0]][13:0], FRAC_BITS'(0)});
			age_q[cnt_q[TI-1:0]] <= 8'd1;
			miss_q[cnt_q[TI-1:0]] <= 5'd0;
		end
		if (cmd.compact_step && keep) begin
			tx_q[ws] <= tx_q[rs]; ty_q[ws] <= ty_q[rs];
			tw_q[ws] <= tw_q[rs]; th_q[ws] <= th_q[rs];
			for (int k = 0; k < 4; k++) s_q[ws][k] <= s_q[rs][k];
			age_q[ws] <= age_q[rs];
			miss_q[ws] <= miss_q[rs];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; pcnt_q <= '0; lost_q <= 1'b0;
			idx_q <= '0; v_s1 <= 1'b0; v_s2 <= 1'b0;
			bf_q <= 1'b0; bi_q <= '0; bu_q <= 29'd1; bj_q <= '0; match_q <= 1'b0;
			rd_q <= '0; wr_q <= '0;
		end else begin
			if (cmd.emit_empty || (cmd.emit_step && hit && !more)) lost_q <= 1'b0;
			if (cmd.scan_clear) begin
				idx_q <= '0; v_s1 <= 1'b0; v_s2 <= 1'b0;
				bf_q <= 1'b0; bi_q <= '0; bu_q <= 29'd1; rd_q <= '0; wr_q <= '0;
			end
			if (cmd.start) begin
				pcnt_q <= '0; lost_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				v_s1 <= idx_q < cnt_q;
				if (idx_q < cnt_q) idx_q <= idx_q + 1'b1;
				v_s2 <= v_s1;
				if (v_s2 && in_s2 != 28'd0 && (!bf_q || lhs > rhs)) begin
					bf_q <= 1'b1; bi_q <= in_s2; bu_q <= un_s2; bj_q <= j_s2;
				end
			end
			match_q <= bf_q && (thr_l >= thr_r);
			if (cmd.pend_store) begin
				if (pcnt_q < (PI+1)'(MAX_PENDING)) pcnt_q <= pcnt_q + 1'b1;
				else lost_q <= 1'b1;
			end
			if (cmd.append_step) begin
				rd_q <= rd_q + 1'b1;
				if (cnt_q < (TI+1)'(MAX_TRACKS)) cnt_q <= cnt_q + 1'b1;
				else lost_q <= 1'b1;
			end
			if (cmd.append_done) begin
				pcnt_q <= '0; rd_q <= '0; wr_q <= '0;
			end
			if (cmd.compact_step) begin
				if (sts.compact_done) begin
					cnt_q <= wr_q; rd_q <= '0;
				end else begin
					rd_q <= rd_q + 1'b1;
					if (keep) wr_q <= wr_q + 1'b1;
				end
			end
			if (cmd.emit_step) rd_q <= nxt;
		end
	end

endmodule

[src/iou_box_tracker.sv]
// ----------------------------------------------------------------------------
// iou_box_tracker
// Greedy IoU tracker of rectangles with EMA smoothing of matched boxes.
// ----------------------------------------------------------------------------
// Input channel carries frame start, rectangle and frame end requests.
// A rectangle request takes one pass of the shared IoU multipliers over the
// stored tracks, the pipeline drain, the decision and the update.
// A frame end appends the pending rectangles and compacts the table, then
// results leave through the output register, one per published track, or a
// single empty result when none is published; every frame end gives at
// least one result, the final one with last set. A stalled receiver holds the
// output register and the sequencer waits. Reset empties the track table and
// pending store and loads register defaults. Registers are written over the
// APB-style port; the user must write them only while idle, the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module iou_box_tracker import ibt_pkg::*; #(
	parameter int MAX_TRACKS  = 16,
	parameter int MAX_PENDING = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [12:0] rect_x,
	input  logic [12:0] rect_y,
	input  logic [13:0] rect_w,
	input  logic [13:0] rect_h,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] box_x,
	output logic [13:0] box_y,
	output logic [13:0] box_w,
	output logic [13:0] box_h,
	output logic        present,
	output logic        last,
	output logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [8:0]  iou_q, gain_q;
	logic [4:0]  age_q, miss_q;
	logic [13:0] fw_q, fh_q;
	cmd_t cmd;
	sts_t sts;
	logic o_load, ov_q, in_take;
	logic [2:0] ra;

	assign pready = 1'b1;
	assign ra = paddr[4:2];
	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_q <= 9'd77; gain_q <= 9'd128; age_q <= 5'd2; miss_q <= 5'd1;
			fw_q <= 14'd1920; fh_q <= 14'd1080;
		end else if (psel && penable && pwrite) begin
			case (ra)
				REG_IOU:    iou_q <= pwdata[8:0];
				REG_GAIN:   gain_q <= pwdata[8:0];
				REG_AGE:    age_q <= pwdata[4:0];
				REG_MISS:   miss_q <= pwdata[4:0];
				REG_WIDTH:  fw_q <= pwdata[13:0];
				REG_HEIGHT: fh_q <= pwdata[13:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (ra)
			REG_IOU:    prdata = {23'd0, iou_q};
			REG_GAIN:   prdata = {23'd0, gain_q};
			REG_AGE:    prdata = {27'd0, age_q};
			REG_MISS:   prdata = {27'd0, miss_q};
			REG_WIDTH:  prdata = {18'd0, fw_q};
			REG_HEIGHT: prdata = {18'd0, fh_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (o_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end
	assign out_valid = ov_q;

	ibt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.out_free (!ov_q || out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ibt_datapath #(
		.MAX_TRACKS  (MAX_TRACKS),
		.MAX_PENDING (MAX_PENDING),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_take        (in_take),
		.rect_x         (rect_x),
		.rect_y         (rect_y),
		.rect_w         (rect_w),
		.rect_h         (rect_h),
		.iou_limit      (iou_q),
		.smoothing_gain (gain_q),
		.min_age        (age_q),
		.miss_limit     (miss_q),
		.frame_width    (fw_q),
		.frame_height   (fh_q),
		.o_load         (o_load),
		.o_x            (box_x),
		.o_y            (box_y),
		.o_w            (box_w),
		.o_h            (box_h),
		.o_present      (present),
		.o_last         (last),
		.o_overflow     (overflow)
	);

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the IoU box tracker: frames of rectangle requests
// are driven with random idling on both channels while a scoreboard predicts
// every published box and checks each result as it leaves the block.
// ----------------------------------------------------------------------------
module testbench import ibt_pkg::*; ();

	localparam int SLOTS      = 16;
	localparam int CYCLE_CAP  = 1000000;
	localparam int SETTLE     = 80;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [13:0] x;
		logic [13:0] y;
		logic [13:0] w;
		logic [13:0] h;
		logic        present;
		logic        last;
		logic        overflow;
	} box_result_t;

	class track_board;
		int unsigned iou_limit, gain, min_age, miss_limit, fwidth, fheight;
		bit              valid[SLOTS];
		int unsigned     box[SLOTS][4];
		longint unsigned smooth[SLOTS][4];
		int unsigned     age[SLOTS];
		int unsigned     miss[SLOTS];
		int unsigned     pend[SLOTS][4];
		int              pend_cnt;
		bit              lost;
		box_result_t     due_boxes[$];
		int              errors;

		function new();
			iou_limit = 77; gain = 128; min_age = 2; miss_limit = 1;
			fwidth = 1920; fheight = 1080;
			foreach (valid[j]) valid[j] = 1'b0;
			pend_cnt = 0;
			lost = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, int unsigned v);
			case (idx)
				REG_IOU: iou_limit = v & 'h1FF;
				REG_GAIN: gain = v & 'h1FF;
				REG_AGE: min_age = v & 'h1F;
				REG_MISS: miss_limit = v & 'h1F;
				REG_WIDTH: fwidth = v & 'h3FFF;
				REG_HEIGHT: fheight = v & 'h3FFF;
				default: ;
			endcase
		endfunction

		function int unsigned rounded(longint unsigned s, int unsigned bound);
			longint unsigned r;
			r = (s + 128) >> 8;
			return (r > bound) ? bound : int'(r);
		endfunction

		function void match_rect(int unsigned r[4]);
			longint unsigned best_i, best_u, ar, inter, uni;
			int unsigned lim, g, x1, y1, x2, y2, iw, ih;
			int bi;
			best_i = 0; best_u = 1; bi = -1;
			ar = longint'(r[2]) * r[3];
			lim = (iou_limit > 256) ? 256 : iou_limit;
			g = (gain > 256) ? 256 : gain;
			for (int j = 0; j < SLOTS; j++) begin
				if (valid[j]) begin
					x1 = (r[0] > box[j][0]) ? r[0] : box[j][0];
					y1 = (r[1] > box[j][1]) ? r[1] : box[j][1];
					x2 = ((r[0] + r[2]) < (box[j][0] + box[j][2])) ? r[0] + r[2]
						: box[j][0] + box[j][2];
					y2 = ((r[1] + r[3]) < (box[j][1] + box[j][3])) ? r[1] + r[3]
						: box[j][1] + box[j][3];
					iw = (x2 > x1) ? x2 - x1 : 0;
					ih = (y2 > y1) ? y2 - y1 : 0;
					inter = longint'(iw) * ih;
					if (inter != 0) begin
						uni = ar + longint'(box[j][2]) * box[j][3] - inter;
						if (bi < 0 || inter * best_u > best_i * uni) begin
							best_i = inter; best_u = uni; bi = j;
						end
					end
				end
			end
			if (bi >= 0 && best_i * 256 >= longint'(lim) * best_u) begin
				for (int k = 0; k < 4; k++) begin
					box[bi][k] = r[k];
					smooth[bi][k] = (longint'(g) * (longint'(r[k]) << 8)
						+ longint'(256 - g) * smooth[bi][k] + 128) >> 8;
				end
				if (age[bi] < 255) age[bi]++;
				miss[bi] = 0;
			end else if (pend_cnt < SLOTS) begin
				for (int k = 0; k < 4; k++) pend[pend_cnt][k] = r[k];
				pend_cnt++;
			end else begin
				lost = 1'b1;
			end
		endfunction

		function void close_frame();
			int cnt, w, n;
			int unsigned fw, fh, need;
			box_result_t res;
			fw = (fwidth < 1) ? 1 : (fwidth > 8192) ? 8192 : fwidth;
			fh = (fheight < 1) ? 1 : (fheight > 8192) ? 8192 : fheight;
			need = (min_age < 1) ? 1 : min_age;
			cnt = 0;
			foreach (valid[j]) if (valid[j]) cnt++;
			for (int p = 0; p < pend_cnt; p++) begin
				if (cnt >= SLOTS) begin
					lost = 1'b1;
				end else begin
					for (int k = 0; k < 4; k++) begin
						box[cnt][k] = pend[p][k];
						smooth[cnt][k] = longint'(pend[p][k]) << 8;
					end
					age[cnt] = 1; miss[cnt] = 0; valid[cnt] = 1'b1;
					cnt++;
				end
			end
			pend_cnt = 0;
			w = 0;
			for (int j = 0; j < SLOTS; j++) begin
				if (valid[j] && miss[j] <= miss_limit) begin
					box[w] = box[j];
					smooth[w] = smooth[j];
					age[w] = age[j];
					miss[w] = miss[j];
					valid[w] = 1'b1;
					w++;
				end
			end
			for (int j = w; j < SLOTS; j++) valid[j] = 1'b0;
			n = 0;
			for (int j = 0; j < w; j++) begin
				if (age[j] >= need && miss[j] == 0) begin
					res.x = rounded(smooth[j][0], fw);
					res.y = rounded(smooth[j][1], fh);
					res.w = rounded(smooth[j][2], fw);
					res.h = rounded(smooth[j][3], fh);
					res.present = 1'b1;
					res.last = 1'b0;
					res.overflow = lost;
					due_boxes.insert(due_boxes.size(), res);
					n++;
				end
			end
			if (n == 0) begin
				res = '0;
				res.overflow = lost;
				due_boxes.insert(due_boxes.size(), res);
			end
			due_boxes[$].last = 1'b1;
			lost = 1'b0;
		endfunction

		function void note_request(logic [1:0] act, int unsigned x, int unsigned y,
				int unsigned w, int unsigned h);
			int unsigned r[4];
			case (act)
				ACT_START: begin
					foreach (valid[j]) if (valid[j] && miss[j] < 31) miss[j]++;
					pend_cnt = 0;
					lost = 1'b0;
				end
				ACT_RECT: begin
					r[0] = x; r[1] = y; r[2] = w; r[3] = h;
					match_rect(r);
				end
				ACT_END: close_frame();
				default: ;
			endcase
		endfunction

		function void check_result(box_result_t got);
			box_result_t exp;
			if (due_boxes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: x %0d y %0d w %0d h %0d p %0b l %0b o %0b",
						got.x, got.y, got.w, got.h, got.present, got.last, got.overflow);
				return;
			end
			exp = due_boxes.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected x %0d y %0d w %0d h %0d p %0b l %0b o %0b",
						exp.x, exp.y, exp.w, exp.h, exp.present, exp.last, exp.overflow);
					$display("          got      x %0d y %0d w %0d h %0d p %0b l %0b o %0b",
						got.x, got.y, got.w, got.h, got.present, got.last, got.overflow);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [12:0] rect_x, rect_y;
	logic [13:0] rect_w, rect_h;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] box_x, box_y, box_w, box_h;
	logic        present, last, overflow;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	track_board board;
	int send_idle, recv_idle, hold_left, cycles, sent;
	int obj_x[4], obj_y[4], obj_w[4], obj_h[4];

	iou_box_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
		.out_valid(out_valid), .out_ready(out_ready),
		.box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
		.present(present), .last(last), .overflow(overflow),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result('{box_x, box_y, box_w, box_h, present, last, overflow});
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send(logic [1:0] act, int unsigned x, int unsigned y,
			int unsigned w, int unsigned h);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rect_x <= 13'(x);
		rect_y <= 13'(y);
		rect_w <= 14'(w);
		rect_h <= 14'(h);
		do @(posedge clk); while (!in_ready);
		board.note_request(act, x, y, w, h);
		if (act != ACT_SPARE) sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, int unsigned v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		board.write_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic configure(int set);
		int unsigned v[6];
		case (set)
			0: v = '{77, 128, 2, 1, 1920, 1080};
			1: v = '{0, 256, 1, 0, 1, 1};
			2: v = '{256, 0, 30, 30, 8192, 8192};
			3: v = '{511, 300, 0, 31, 0, 16383};
			default: v = '{$urandom_range(200, 20), $urandom_range(256), $urandom_range(4, 1),
				$urandom_range(3), $urandom_range(8192, 64), $urandom_range(8192, 64)};
		endcase
		apb_write(REG_IOU, v[0]);
		apb_write(REG_GAIN, v[1]);
		apb_write(REG_AGE, v[2]);
		apb_write(REG_MISS, v[3]);
		apb_write(REG_WIDTH, v[4]);
		apb_write(REG_HEIGHT, v[5]);
	endtask

	function automatic int unsigned jitter(int v, int span, int hi);
		int t;
		t = v + $urandom_range(2 * span) - span;
		return (t < 0) ? 0 : (t > hi) ? hi : t;
	endfunction

	task automatic seed_objects();
		for (int i = 0; i < 4; i++) begin
			obj_x[i] = $urandom_range(2000);
			obj_y[i] = $urandom_range(1200);
			obj_w[i] = $urandom_range(300, 20);
			obj_h[i] = $urandom_range(300, 20);
		end
	endtask

	task automatic crowded_frame(int base);
		send(ACT_START, 0, 0, 0, 0);
		for (int i = 0; i < 18; i++)
			send(ACT_RECT, base + i * 400, base, 100, 100);
		send(ACT_END, 0, 0, 0, 0);
	endtask

	task automatic random_frame();
		int n, pick, sel;
		n = $urandom_range(6);
		if ($urandom_range(19) != 0) send(ACT_START, 0, 0, 0, 0);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			sel = $urandom_range(3);
			if (pick < 70) begin
				obj_x[sel] = jitter(obj_x[sel], 4, 8191);
				obj_y[sel] = jitter(obj_y[sel], 4, 8191);
				send(ACT_RECT, obj_x[sel], obj_y[sel], jitter(obj_w[sel], 3, 8192),
					jitter(obj_h[sel], 3, 8192));
			end else if (pick < 85) begin
				send(ACT_RECT, $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8192), $urandom_range(8192));
			end else if (pick < 95) begin
				send(ACT_RECT, $urandom_range(1000), $urandom_range(1000),
					$urandom_range(64), $urandom_range(64));
			end else begin
				send(ACT_SPARE, $urandom_range(8191), $urandom_range(8191),
					$urandom_range(16383), $urandom_range(16383));
			end
		end
		if ($urandom_range(19) != 0) send(ACT_END, 0, 0, 0, 0);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_START;
		rect_x = '0; rect_y = '0; rect_w = '0; rect_h = '0;
		out_ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		send_idle = 0; recv_idle = 0; hold_left = 0; cycles = 0; sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACT_START, 0, 0, 0, 0);
		send(ACT_END, 0, 0, 0, 0);
		send(ACT_START, 0, 0, 0, 0);
		send(ACT_RECT, 100, 100, 50, 50);
		send(ACT_RECT, 0, 0, 0, 0);
		send(ACT_RECT, 8191, 8191, 8192, 8192);
		send(ACT_END, 0, 0, 0, 0);
		send(ACT_START, 0, 0, 0, 0);
		send(ACT_RECT, 102, 101, 50, 50);
		send(ACT_RECT, 8191, 8191, 8192, 8192);
		send(ACT_SPARE, 8191, 8191, 16383, 16383);
		send(ACT_END, 0, 0, 0, 0);
		send(ACT_START, 0, 0, 0, 0);
		send(ACT_RECT, 0, 0, 8192, 8192);
		send(ACT_RECT, 140, 100, 50, 50);
		send(ACT_END, 0, 0, 0, 0);
		send(ACT_END, 0, 0, 0, 0);
		send(ACT_START, 0, 0, 0, 0);
		send(ACT_RECT, 500, 500, 20, 20);
		send(ACT_START, 0, 0, 0, 0);
		send(ACT_END, 0, 0, 0, 0);
		drain();

		for (int blk = 0; blk < 6; blk++) begin
			case (blk / 2)
				0: begin send_idle = 29; recv_idle = 72; end
				1: begin send_idle = 72; recv_idle = 29; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			configure(blk);
			seed_objects();
			sent = 0;
			crowded_frame(10);
			crowded_frame(60);
			for (int f = 0; sent < 66; f++) begin
				if (blk == 0 && f == 3) hold_left = 400;
				if (blk == 1 && f == 5) drain();
				if ($urandom_range(9) == 0) seed_objects();
				random_frame();
			end
			drain();
		end

		if (board.errors == 0 && board.due_boxes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
